/* rtl/fbm_pkg.sv */
// shared constants, types and helpers for the byte buffer mutator
`timescale 1ns / 1ps

package fbm_pkg;

    // buffer geometry
    localparam int MAX_LEN     = 256;
    localparam int ARITH_LIMIT = 35;
    localparam int BANK_DEPTH  = MAX_LEN / 2;
    localparam int BANK_AW     = $clog2(BANK_DEPTH);
    localparam int LEN_W       = 9;

    // action codes
    localparam logic [2:0] ACT_WRITE    = 3'd0;
    localparam logic [2:0] ACT_READ     = 3'd1;
    localparam logic [2:0] ACT_RANDOM   = 3'd2;
    localparam logic [2:0] ACT_ADDSUB   = 3'd3;
    localparam logic [2:0] ACT_FLIP     = 3'd4;
    localparam logic [2:0] ACT_INTEREST = 3'd5;

    // decoded request handed from the address stage to the update stage
    typedef struct packed {
        logic [2:0]  action;
        logic        reject;
        logic [2:0]  shift;
        logic [3:0]  count;
        logic        wide;
        logic        subtract;
        logic [5:0]  delta;
        logic [15:0] operand;
    } op_t;

    // byte updates and result produced by the update stage
    typedef struct packed {
        logic       we_lo;
        logic       we_hi;
        logic [7:0] lo_new;
        logic [7:0] hi_new;
        logic [7:0] read_data;
        logic       rejected;
    } upd_t;

    // top n bits of a byte, n in 0..8
    function automatic logic [7:0] top_mask(input logic [3:0] n);
        logic [15:0] t;
        t = 16'hFF00 >> n;
        return t[7:0];
    endfunction

endpackage

/* rtl/fuzz_byte_buffer_mutator_top.sv */
// top level of the byte buffer mutator: request decode, two-bank store, result register
`timescale 1ns / 1ps

// The mutator accepts one request per cycle while the result side does not stall, and
// passes it through a decode register, a memory read register and a result register.
// The 256-byte store is split into even and odd banks with registered reads, so
// a byte request and a little-endian word request both read and write their
// bytes in one pass; a write still in flight is bypassed into the read of the
// following request. Back-pressure on the result side stalls the whole pipe.
// buffer_length is to be written by the user through cfg_we/cfg_data only while no
// request is in flight (not enforced); bytes must be written before they are read.

module fuzz_byte_buffer_mutator_top
    import fbm_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [LEN_W-1:0] cfg_data,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [2:0]       action,
    input  logic [7:0]       byte_index,
    input  logic [10:0]      bit_position,
    input  logic [3:0]       bit_count,
    input  logic             wide,
    input  logic             subtract,
    input  logic [5:0]       amount,
    input  logic [15:0]      operand,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       read_data,
    output logic             rejected
);

    logic             adv;
    logic [LEN_W-1:0] len_reg;

    // decode stage registers
    logic             s1_valid_reg;
    op_t              s1_op_reg;
    logic [7:0]       s1_byte_reg;

    // update stage registers
    logic             s2_valid_reg;
    op_t              s2_op_reg;
    logic             s2_odd_reg;
    logic [BANK_AW-1:0] s2_even_addr_reg;
    logic [BANK_AW-1:0] s2_odd_addr_reg;
    logic             fwd_even_reg;
    logic             fwd_odd_reg;
    logic [7:0]       fwd_even_data_reg;
    logic [7:0]       fwd_odd_data_reg;

    // result registers
    logic             out_valid_reg;
    logic [7:0]       read_data_reg;
    logic             rejected_reg;

    // decode signals
    op_t              s1_op_next;
    logic [7:0]       byte_sel;
    logic [11:0]      run_end;
    logic [11:0]      bit_limit;
    logic [4:0]       run_len;
    logic             len_bad;

    // bank addressing
    logic [8:0]         hi_index;
    logic [BANK_AW-1:0] even_raddr;
    logic [BANK_AW-1:0] odd_raddr;
    logic [7:0]         even_rdata;
    logic [7:0]         odd_rdata;
    logic [7:0]         even_byte;
    logic [7:0]         odd_byte;
    logic [7:0]         lo_byte;
    logic [7:0]         hi_byte;

    // update stage signals
    upd_t               upd;
    logic               even_we;
    logic               odd_we;
    logic [7:0]         even_wdata;
    logic [7:0]         odd_wdata;

    // pipe advances whenever the result register can take a new value
    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;

    // configuration register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= LEN_W'(MAX_LEN);
        end
        else if (cfg_we)
        begin
            len_reg <= cfg_data;
        end
    end

    // request decode and range check
    always_comb
    begin
        byte_sel  = (action inside {ACT_WRITE, ACT_READ}) ? byte_index : bit_position[10:3];
        run_len   = (action inside {ACT_RANDOM, ACT_FLIP}) ? {1'b0, bit_count}
                  : (wide ? 5'd16 : 5'd8);
        run_end   = {1'b0, bit_position} + {7'd0, run_len};
        bit_limit = {len_reg, 3'b000};
        len_bad   = len_reg > LEN_W'(MAX_LEN);

        s1_op_next          = '0;
        s1_op_next.action   = action;
        s1_op_next.shift    = bit_position[2:0];
        s1_op_next.count    = bit_count;
        s1_op_next.wide     = wide;
        s1_op_next.subtract = subtract;
        s1_op_next.delta    = (amount > 6'(ARITH_LIMIT)) ? 6'(ARITH_LIMIT) : amount;
        s1_op_next.operand  = operand;

        case (action)
            ACT_WRITE, ACT_READ:
            begin
                s1_op_next.reject = len_bad || ({1'b0, byte_index} >= len_reg);
            end
            ACT_RANDOM, ACT_FLIP:
            begin
                s1_op_next.reject = len_bad || (bit_count == 4'd0) || (bit_count > 4'd8)
                                  || (run_end > bit_limit);
            end
            ACT_ADDSUB, ACT_INTEREST:
            begin
                s1_op_next.reject = len_bad || (run_end > bit_limit);
            end
            default:
            begin
                s1_op_next.reject = 1'b0;
            end
        endcase
    end

    // decode stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_op_reg   <= s1_op_next;
            s1_byte_reg <= byte_sel;
        end
    end

    // low byte goes to the bank of its parity, high byte to the other one
    always_comb
    begin
        hi_index   = {1'b0, s1_byte_reg} + 9'd1;
        even_raddr = s1_byte_reg[0] ? hi_index[BANK_AW:1] : s1_byte_reg[BANK_AW:1];
        odd_raddr  = s1_byte_reg[0] ? s1_byte_reg[BANK_AW:1] : hi_index[BANK_AW:1];
    end

    fbm_bank u_even (
        .clk   (clk),
        .en    (adv),
        .we    (even_we),
        .waddr (s2_even_addr_reg),
        .wdata (even_wdata),
        .raddr (even_raddr),
        .rdata (even_rdata)
    );

    fbm_bank u_odd (
        .clk   (clk),
        .en    (adv),
        .we    (odd_we),
        .waddr (s2_odd_addr_reg),
        .wdata (odd_wdata),
        .raddr (odd_raddr),
        .rdata (odd_rdata)
    );

    // update stage control and bypass of the write in flight
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
            fwd_even_reg <= 1'b0;
            fwd_odd_reg  <= 1'b0;
        end
        else if (adv)
        begin
            s2_valid_reg <= s1_valid_reg;
            fwd_even_reg <= even_we && (s2_even_addr_reg == even_raddr);
            fwd_odd_reg  <= odd_we && (s2_odd_addr_reg == odd_raddr);
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_op_reg         <= s1_op_reg;
            s2_odd_reg        <= s1_byte_reg[0];
            s2_even_addr_reg  <= even_raddr;
            s2_odd_addr_reg   <= odd_raddr;
            fwd_even_data_reg <= even_wdata;
            fwd_odd_data_reg  <= odd_wdata;
        end
    end

    // read data with bypass, reordered to low and high byte
    always_comb
    begin
        even_byte = fwd_even_reg ? fwd_even_data_reg : even_rdata;
        odd_byte  = fwd_odd_reg ? fwd_odd_data_reg : odd_rdata;
        lo_byte   = s2_odd_reg ? odd_byte : even_byte;
        hi_byte   = s2_odd_reg ? even_byte : odd_byte;
    end

    fbm_alu u_alu (
        .op      (s2_op_reg),
        .lo_byte (lo_byte),
        .hi_byte (hi_byte),
        .upd     (upd)
    );

    // map byte updates back onto the banks
    always_comb
    begin
        even_we    = s2_valid_reg && (s2_odd_reg ? upd.we_hi : upd.we_lo);
        odd_we     = s2_valid_reg && (s2_odd_reg ? upd.we_lo : upd.we_hi);
        even_wdata = s2_odd_reg ? upd.hi_new : upd.lo_new;
        odd_wdata  = s2_odd_reg ? upd.lo_new : upd.hi_new;
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            read_data_reg <= upd.read_data;
            rejected_reg  <= upd.rejected;
        end
    end

    assign out_valid = out_valid_reg;
    assign read_data = read_data_reg;
    assign rejected  = rejected_reg;

endmodule

/* rtl/fbm_bank.sv */
// one bank of the byte store: single write port, registered read port
`timescale 1ns / 1ps

module fbm_bank
    import fbm_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic               we,
    input  logic [BANK_AW-1:0] waddr,
    input  logic [7:0]         wdata,
    input  logic [BANK_AW-1:0] raddr,
    output logic [7:0]         rdata
);

    logic [7:0] mem [BANK_DEPTH];
    logic [7:0] rdata_reg;

    // write port
    always_ff @(posedge clk)
    begin
        if (en && we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read port, old data on a same-cycle collision
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/fbm_alu.sv */
// update stage: computes the new byte values and the result of one request
`timescale 1ns / 1ps

module fbm_alu
    import fbm_pkg::*;
(
    input  op_t        op,
    input  logic [7:0] lo_byte,
    input  logic [7:0] hi_byte,
    output upd_t       upd
);

    logic [7:0]  mask;
    logic [7:0]  mask_sh;
    logic [15:0] word;
    logic [15:0] word_new;

    // bit run mask and word arithmetic
    always_comb
    begin
        mask     = top_mask(op.count);
        mask_sh  = mask >> op.shift;
        word     = {hi_byte, lo_byte};
        word_new = op.subtract ? (word - {10'd0, op.delta}) : (word + {10'd0, op.delta});
    end

    // per-action update
    always_comb
    begin
        upd           = '0;
        upd.lo_new    = lo_byte;
        upd.hi_new    = hi_byte;
        upd.rejected  = op.reject;
        if (!op.reject)
        begin
            case (op.action)
                ACT_WRITE:
                begin
                    upd.we_lo  = 1'b1;
                    upd.lo_new = op.operand[7:0];
                end
                ACT_READ:
                begin
                    upd.read_data = lo_byte;
                end
                ACT_RANDOM:
                begin
                    upd.we_lo  = 1'b1;
                    upd.lo_new = (lo_byte & ~mask_sh) | ((op.operand[7:0] & mask) >> op.shift);
                end
                ACT_FLIP:
                begin
                    upd.we_lo  = 1'b1;
                    upd.lo_new = lo_byte ^ mask_sh;
                end
                ACT_ADDSUB:
                begin
                    upd.we_lo  = 1'b1;
                    upd.we_hi  = op.wide;
                    upd.lo_new = word_new[7:0];
                    upd.hi_new = word_new[15:8];
                end
                ACT_INTEREST:
                begin
                    upd.we_lo  = 1'b1;
                    upd.we_hi  = op.wide;
                    upd.lo_new = op.operand[7:0];
                    upd.hi_new = op.operand[15:8];
                end
                default:
                begin
                    upd.we_lo = 1'b0;
                end
            endcase
        end
    end

endmodule
